// ----- rtl/ede_pkg.sv -----
// ----------------------------------------------------------------------------
// ede_pkg
// Shared types and constants for the decimal escape decoder.
// ----------------------------------------------------------------------------
package ede_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BYTE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE_MARKER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE_OUT    = 2'd2;

  // Register reset values
  localparam logic [7:0] RST_ESCAPE_BYTE  = 8'd92;
  localparam logic [7:0] RST_QUOTE_MARKER = 8'd161;
  localparam logic [7:0] RST_QUOTE_OUT    = 8'd39;

  // ASCII digit range
  localparam logic [7:0] DIGIT_LOW  = 8'h30;
  localparam logic [7:0] DIGIT_HIGH = 8'h39;

  // Output queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_final;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       value_end;
  } out_item_t;

  typedef struct packed {
    logic [7:0] escape_byte;
    logic [7:0] quote_marker;
    logic [7:0] quote_out;
  } cfg_t;

  // Up to two results per decoded item
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  res0;
    out_item_t  res1;
  } dec_res_t;

endpackage

// ----- rtl/ede_decode.sv -----
// ----------------------------------------------------------------------------
// ede_decode
// Escape state machine and decimal accumulator; one item per item_go cycle.
// ----------------------------------------------------------------------------
module ede_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_go,
  input  ede_pkg::in_item_t item,
  input  ede_pkg::cfg_t     cfg,
  output ede_pkg::dec_res_t res
);

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_DIGITS = 2'd2
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [7:0] accum_r, accum_nxt;

  logic [7:0] b;
  logic       fin;
  logic       is_digit;
  logic [7:0] digit_val;
  logic [7:0] byte0, byte1;
  logic [1:0] cnt;

  assign b         = item.in_byte;
  assign fin       = item.in_final;
  assign is_digit  = (b >= ede_pkg::DIGIT_LOW) && (b <= ede_pkg::DIGIT_HIGH);
  assign digit_val = b - ede_pkg::DIGIT_LOW;

  always_comb begin
    mode_nxt  = mode_r;
    accum_nxt = accum_r;
    byte0     = b;
    byte1     = b;
    cnt       = 2'd0;

    unique case (mode_r)
      MODE_ESCAPE: begin
        if (b == cfg.escape_byte) begin
          byte0    = cfg.escape_byte;
          cnt      = 2'd1;
          mode_nxt = MODE_NORMAL;
        end else if (b == cfg.quote_marker) begin
          byte0    = cfg.quote_out;
          cnt      = 2'd1;
          mode_nxt = MODE_NORMAL;
        end else if (is_digit) begin
          accum_nxt = digit_val;
          mode_nxt  = MODE_DIGITS;
        end else begin
          byte0    = b;
          cnt      = 2'd1;
          mode_nxt = MODE_NORMAL;
        end
      end
      MODE_DIGITS: begin
        if (is_digit) begin
          // accum * 10 + digit, modulo 256
          accum_nxt = {accum_r[4:0], 3'b000} + {accum_r[6:0], 1'b0} + digit_val;
        end else begin
          byte0     = accum_r;
          cnt       = 2'd1;
          accum_nxt = '0;
          if (b == cfg.escape_byte && !fin) begin
            mode_nxt = MODE_ESCAPE;
          end else begin
            byte1    = b;
            cnt      = 2'd2;
            mode_nxt = MODE_NORMAL;
          end
        end
      end
      default: begin
        if (b == cfg.escape_byte && !fin) begin
          mode_nxt = MODE_ESCAPE;
        end else begin
          byte0    = b;
          cnt      = 2'd1;
          mode_nxt = MODE_NORMAL;
        end
      end
    endcase

    // End of value flushes a pending number and clears state
    if (fin) begin
      if (mode_nxt == MODE_DIGITS) begin
        // digits only ever follow with no result in this item
        byte0 = accum_nxt;
        cnt   = 2'd1;
      end
      mode_nxt  = MODE_NORMAL;
      accum_nxt = '0;
    end
  end

  always_comb begin
    res                = '0;
    res.cnt            = cnt;
    res.res0.out_byte  = byte0;
    res.res1.out_byte  = byte1;
    res.res0.run_last  = (cnt == 2'd1);
    res.res0.value_end = (cnt == 2'd1) && fin;
    res.res1.run_last  = (cnt == 2'd2);
    res.res1.value_end = (cnt == 2'd2) && fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      accum_r <= '0;
    end else if (item_go) begin
      mode_r  <= mode_nxt;
      accum_r <= accum_nxt;
    end
  end

  // A final item always leaves normal mode and a cleared accumulator
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    item_go && fin |=> mode_r == MODE_NORMAL && accum_r == 8'd0)
    else $error("final item did not clear decode state");

  // A final item always yields at least one result
  a_final_emits: assert property (@(posedge clk) disable iff (!rst_n)
    item_go && fin |-> cnt != 2'd0)
    else $error("final item produced no result");

  // Two results only come out of digit mode
  a_two_from_digits: assert property (@(posedge clk) disable iff (!rst_n)
    cnt == 2'd2 |-> mode_r == MODE_DIGITS)
    else $error("two results outside digit mode");

endmodule

// ----- rtl/decimal_escape_decoder.sv -----
// ----------------------------------------------------------------------------
// decimal_escape_decoder
// Streaming decoder for backslash-decimal escaped byte values.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction | moves
//  --------+--------------------------------+-----------+---------------------
//  in      | in_valid, in_ready, in_item    | input     | one raw byte item
//  out     | out_valid, out_ready, out_item | output    | one decoded byte item
//  cfg     | cfg_wr_en, cfg_index, cfg_wdata| input     | register write
//
//  Cycles: one item per cycle while the queue has room for two results.
//  An accepted item is held in the input register, decoded there and
//  pushed into a 4-entry output queue; its first result shows on out_*
//  once it is in the queue. An item yields 0, 1 or 2 results; the queue
//  output takes one per cycle while out_ready is high.
//  Reset: synchronous, active low; clears decode state, queue and registers
//  to their defaults (escape 92, quote marker 161, quote out 39).
//  Stalls: the input register advances only while the queue has room for
//  two results; in_ready drops when the register is full and cannot advance.
// ----------------------------------------------------------------------------
module decimal_escape_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  // input item channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ede_pkg::in_item_t                  in_item,
  // result item channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output ede_pkg::out_item_t                 out_item,
  // configuration write port
  input  logic                               cfg_wr_en,
  input  logic [ede_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                         cfg_wdata
);

  // ---------------- configuration registers ----------------
  ede_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.escape_byte  <= ede_pkg::RST_ESCAPE_BYTE;
      cfg_r.quote_marker <= ede_pkg::RST_QUOTE_MARKER;
      cfg_r.quote_out    <= ede_pkg::RST_QUOTE_OUT;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ede_pkg::CFG_ESCAPE_BYTE:  cfg_r.escape_byte  <= cfg_wdata;
        ede_pkg::CFG_QUOTE_MARKER: cfg_r.quote_marker <= cfg_wdata;
        ede_pkg::CFG_QUOTE_OUT:    cfg_r.quote_out    <= cfg_wdata;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------- input register ----------------
  ede_pkg::in_item_t stg_r;
  logic              stg_vld_r;
  logic              in_go;
  logic              stg_go;

  // output queue state (declared here, used by stage control)
  ede_pkg::out_item_t                q_r [ede_pkg::QUEUE_DEPTH];
  logic [ede_pkg::QPTR_W-1:0]        wr_ptr_r, rd_ptr_r;
  logic [ede_pkg::QCNT_W-1:0]        cnt_r, cnt_nxt;
  logic                              room;
  logic                              pop;

  // room for the worst case of two results, ignoring this cycle's pop
  assign room     = cnt_r <= ede_pkg::QCNT_W'(ede_pkg::QUEUE_DEPTH - 2);
  assign stg_go   = stg_vld_r && room;
  assign in_ready = !stg_vld_r || room;
  assign in_go    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_go) begin
      stg_vld_r <= 1'b1;
    end else if (stg_go) begin
      stg_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      stg_r <= in_item;
    end
  end

  // ---------------- decode ----------------
  ede_pkg::dec_res_t dec;

  ede_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_go (stg_go),
    .item    (stg_r),
    .cfg     (cfg_r),
    .res     (dec)
  );

  // ---------------- output queue ----------------
  logic [1:0]                 push_n;
  logic [ede_pkg::QPTR_W-1:0] wr_ptr_p1;

  assign push_n    = stg_go ? dec.cnt : 2'd0;
  assign out_valid = cnt_r != '0;
  assign out_item  = q_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + ede_pkg::QPTR_W'(1);
  assign cnt_nxt   = cnt_r + ede_pkg::QCNT_W'(push_n) - ede_pkg::QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + ede_pkg::QPTR_W'(push_n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + ede_pkg::QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= dec.res0;
    end
    if (push_n == 2'd2) begin
      q_r[wr_ptr_p1] <= dec.res1;
    end
  end

  // ---------------- checks ----------------
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ede_pkg::QCNT_W'(ede_pkg::QUEUE_DEPTH))
    else $error("output queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_n != 2'd0 |-> room)
    else $error("push without room in output queue");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop && cnt_r == ede_pkg::QCNT_W'(1) && push_n == 2'd0 |=> !out_valid)
    else $error("queue still valid after last item drained");

  a_stage_stall: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld_r && !room |=> stg_vld_r && $stable(stg_r))
    else $error("input register lost its item while stalled");

endmodule

// ----- dv/decimal_escape_decoder_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_escape_decoder_tb
// Self-checking bench for the decimal escape decoder. A table of hand-picked
// bytes comes first, then random values built from escape sequences under
// several register settings and idle patterns. Every decoded byte is checked
// in order against hand-typed results or an in-bench decoder model.
// ----------------------------------------------------------------------------
module decimal_escape_decoder_tb;
  import ede_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int NUM_PHASES   = 6;
  localparam int PHASE_ITEMS  = 140;
  localparam int SETTLE_CYC   = 6;        // pipeline is 2 deep, with margin
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int DIR_N        = 25;

  // Index past the last register; writes there must not disturb anything.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  localparam logic [7:0] ESC   = RST_ESCAPE_BYTE;
  localparam logic [7:0] QMARK = RST_QUOTE_MARKER;
  localparam logic [7:0] QOUT  = RST_QUOTE_OUT;

  typedef enum logic [1:0] {
    MODE_PLAIN,   // ordinary bytes
    MODE_ESC,     // escape byte seen
    MODE_NUM      // collecting decimal digits
  } dec_mode_e;

  // One input item plus, for table rows that are easy to read off, the
  // results typed in by hand. Untyped rows go through the model.
  typedef struct packed {
    in_item_t   item;
    logic       typed;
    logic [1:0] n_res;
    out_item_t  r0;
    out_item_t  r1;
  } stim_t;

  // Directed table, reset register values.
  //  item              typed n  first result       second result
  localparam stim_t DIR_TAB [DIR_N] = '{
    '{'{8'h41, 1'b0}, 1'b1, 2'd1, '{8'h41, 1'b1, 1'b0}, '0},   // plain byte
    '{'{8'h00, 1'b0}, 1'b1, 2'd1, '{8'h00, 1'b1, 1'b0}, '0},   // low extreme
    '{'{8'hFF, 1'b1}, 1'b1, 2'd1, '{8'hFF, 1'b1, 1'b1}, '0},   // high extreme, ends value
    '{'{ESC,   1'b0}, 1'b1, 2'd0, '0, '0},
    '{'{ESC,   1'b0}, 1'b1, 2'd1, '{ESC, 1'b1, 1'b0}, '0},     // escaped escape
    '{'{ESC,   1'b0}, 1'b1, 2'd0, '0, '0},
    '{'{QMARK, 1'b0}, 1'b1, 2'd1, '{QOUT, 1'b1, 1'b0}, '0},    // escaped quote
    '{'{ESC,   1'b0}, 1'b1, 2'd0, '0, '0},
    '{'{8'h32, 1'b0}, 1'b1, 2'd0, '0, '0},
    '{'{8'h35, 1'b0}, 1'b1, 2'd0, '0, '0},
    '{'{8'h35, 1'b0}, 1'b1, 2'd0, '0, '0},
    // 255 flushed by a non-digit, which then goes out itself
    '{'{8'h78, 1'b0}, 1'b1, 2'd2, '{8'hFF, 1'b0, 1'b0}, '{8'h78, 1'b1, 1'b0}},
    '{'{ESC,   1'b0}, 1'b1, 2'd0, '0, '0},
    '{'{8'h33, 1'b0}, 1'b0, 2'd0, '0, '0},
    '{'{8'h30, 1'b0}, 1'b0, 2'd0, '0, '0},
    '{'{8'h30, 1'b1}, 1'b0, 2'd0, '0, '0},                     // 300 wraps, ends value
    '{'{ESC,   1'b1}, 1'b1, 2'd1, '{ESC, 1'b1, 1'b1}, '0},     // trailing escape kept
    '{'{ESC,   1'b0}, 1'b1, 2'd0, '0, '0},
    '{'{8'h71, 1'b0}, 1'b0, 2'd0, '0, '0},                     // escape dropped
    '{'{ESC,   1'b0}, 1'b0, 2'd0, '0, '0},
    '{'{8'h31, 1'b0}, 1'b0, 2'd0, '0, '0},
    '{'{ESC,   1'b1}, 1'b0, 2'd0, '0, '0},                     // number, then final escape
    '{'{ESC,   1'b0}, 1'b0, 2'd0, '0, '0},
    '{'{8'h39, 1'b1}, 1'b0, 2'd0, '0, '0},                     // number ends with value
    '{'{8'h30, 1'b1}, 1'b1, 2'd1, '{8'h30, 1'b1, 1'b1}, '0}    // plain digit
  };

  // DUT signals; those the bench drives are known from time zero
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  out_item_t            out_item;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_wdata = '0;

  // Decoder model state
  cfg_t      dec_cfg   = '{RST_ESCAPE_BYTE, RST_QUOTE_MARKER, RST_QUOTE_OUT};
  dec_mode_e dec_mode  = MODE_PLAIN;
  logic [7:0] dec_accum = '0;
  out_item_t step_res [$];      // bytes decoded by the latest item

  stim_t     stim_q [$];        // items not yet presented
  stim_t     cur_stim;          // item currently on the input port
  out_item_t decoded_q [$];     // decoded bytes still to come out
  out_item_t want_res;

  int gap_pct   = 0;
  int stall_pct = 0;
  int errors    = 0;
  int cycles    = 0;
  int queued    = 0;

  decimal_escape_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------
  function automatic logic is_digit(logic [7:0] b);
    return b >= DIGIT_LOW && b <= DIGIT_HIGH;
  endfunction

  function automatic void put_byte(logic [7:0] v);
    step_res.push_back(out_item_t'{out_byte: v, run_last: 1'b0, value_end: 1'b0});
  endfunction

  // Decodes one item into step_res and advances the model state.
  function automatic void decode_step(in_item_t it);
    logic [7:0] b;
    logic       fin;
    logic       plain;
    b     = it.in_byte;
    fin   = it.in_final;
    plain = 1'b0;
    step_res.delete();

    // After an escape the tests run escape, quote marker, digit, in that
    // order; the first that matches wins.
    case (dec_mode)
      MODE_ESC: begin
        if (b == dec_cfg.escape_byte) begin
          put_byte(dec_cfg.escape_byte);
          dec_mode = MODE_PLAIN;
        end else if (b == dec_cfg.quote_marker) begin
          put_byte(dec_cfg.quote_out);
          dec_mode = MODE_PLAIN;
        end else if (is_digit(b)) begin
          dec_accum = b - DIGIT_LOW;
          dec_mode  = MODE_NUM;
        end else begin
          put_byte(b);
          dec_mode = MODE_PLAIN;
        end
      end
      MODE_NUM: begin
        // any digit continues the number, even one equal to a register
        if (is_digit(b)) begin
          dec_accum = dec_accum * 8'd10 + (b - DIGIT_LOW);
        end else begin
          put_byte(dec_accum);
          dec_accum = '0;
          plain     = 1'b1;
        end
      end
      default: plain = 1'b1;
    endcase

    if (plain) begin
      if (b == dec_cfg.escape_byte && !fin) begin
        dec_mode = MODE_ESC;
      end else begin
        put_byte(b);
        dec_mode = MODE_PLAIN;
      end
    end

    if (fin) begin
      if (dec_mode == MODE_NUM) put_byte(dec_accum);
      dec_mode  = MODE_PLAIN;
      dec_accum = '0;
    end

    if (step_res.size() != 0) begin
      step_res[step_res.size()-1].run_last  = 1'b1;
      step_res[step_res.size()-1].value_end = fin;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input side: presents queued items, predicts on every accepted item
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_step(cur_stim.item);
        if (cur_stim.typed) begin
          if (cur_stim.n_res >= 2'd1) decoded_q.push_back(cur_stim.r0);
          if (cur_stim.n_res == 2'd2) decoded_q.push_back(cur_stim.r1);
        end else begin
          foreach (step_res[i]) decoded_q.push_back(step_res[i]);
        end
      end
      // port is free for a new item unless one is still waiting
      if (!in_valid || in_ready) begin
        if (stim_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          cur_stim = stim_q.pop_front();
          in_valid <= 1'b1;
          in_item  <= cur_stim.item;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output side: random back-pressure and in-order compare
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result: out_byte %0d run_last %0d value_end %0d",
               out_item.out_byte, out_item.run_last, out_item.value_end);
        errors++;
      end else begin
        want_res = decoded_q.pop_front();
        if (out_item.out_byte !== want_res.out_byte) begin
          $error("out_byte: expected %0d, got %0d", want_res.out_byte, out_item.out_byte);
          errors++;
        end
        if (out_item.run_last !== want_res.run_last) begin
          $error("run_last: expected %0d, got %0d", want_res.run_last, out_item.run_last);
          errors++;
        end
        if (out_item.value_end !== want_res.value_end) begin
          $error("value_end: expected %0d, got %0d", want_res.value_end,
                 out_item.value_end);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Writes all registers, plus the spare index, back to back. Only called
  // with nothing in flight.
  task automatic load_cfg(input cfg_t c);
    logic [7:0]           vals [4];
    logic [CFG_IDX_W-1:0] idx  [4];
    vals = '{c.escape_byte, c.quote_marker, c.quote_out, 8'($urandom)};
    idx  = '{CFG_ESCAPE_BYTE, CFG_QUOTE_MARKER, CFG_QUOTE_OUT, CFG_IDX_SPARE};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
    end
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    dec_cfg = c;
  endtask

  // Wait until every queued item went in and every decoded byte came out,
  // then let the pipeline run dry (items with no result may still be inside).
  task automatic drain();
    do @(negedge clk);
    while (stim_q.size() != 0 || in_valid || decoded_q.size() != 0);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic add_item(input logic [7:0] b, input logic fin);
    stim_q.push_back(stim_t'{item: in_item_t'{in_byte: b, in_final: fin},
                             typed: 1'b0, n_res: 2'd0, r0: '0, r1: '0});
    queued++;
  endtask

  // Byte biased toward the ones the decoder reacts to.
  function automatic logic [7:0] any_byte();
    case ($urandom_range(7))
      0:       return dec_cfg.escape_byte;
      1:       return dec_cfg.quote_marker;
      2, 3:    return DIGIT_LOW + 8'($urandom_range(9));
      default: return 8'($urandom);
    endcase
  endfunction

  // One value: mostly well-formed escape sequences, sometimes raw noise.
  task automatic gen_value();
    logic [7:0] seq [$];
    int         ntok;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(4, 1)) add_item(8'($urandom), 1'($urandom));
      return;
    end
    ntok = $urandom_range(5, 1);
    repeat (ntok) begin
      case ($urandom_range(9))
        0, 1, 2: seq.push_back(any_byte());
        3: begin
          seq.push_back(dec_cfg.escape_byte);
          seq.push_back(dec_cfg.escape_byte);
        end
        4: begin
          seq.push_back(dec_cfg.escape_byte);
          seq.push_back(dec_cfg.quote_marker);
        end
        5, 6, 7: begin
          seq.push_back(dec_cfg.escape_byte);
          repeat ($urandom_range(4, 1)) seq.push_back(DIGIT_LOW + 8'($urandom_range(9)));
        end
        default: begin
          seq.push_back(dec_cfg.escape_byte);
          seq.push_back(any_byte());
        end
      endcase
    end
    if ($urandom_range(7) == 0) seq.push_back(dec_cfg.escape_byte);   // trailing escape
    foreach (seq[i]) add_item(seq[i], i == seq.size() - 1);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_t       phase_cfg;
    logic [7:0] shared;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      // registers change only here, with the decoder idle
      shared = 8'($urandom);
      case (p)
        0:       phase_cfg = dec_cfg;
        1:       phase_cfg = '{8'h00, 8'hFF, 8'h00};
        2:       phase_cfg = '{8'hFF, 8'h00, 8'hFF};
        // escape and quote marker are digits themselves
        3:       phase_cfg = '{DIGIT_LOW + 8'd5, DIGIT_LOW + 8'd7, 8'($urandom)};
        // escape and quote marker equal: escape must win
        4:       phase_cfg = '{shared, shared, 8'($urandom)};
        default: phase_cfg = '{8'($urandom), 8'($urandom), 8'($urandom)};
      endcase
      if (p != 0) load_cfg(phase_cfg);

      @(negedge clk);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 47; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 47; end
        default: begin gap_pct = 28; stall_pct = 28; end
      endcase

      if (p == 0) begin
        foreach (DIR_TAB[i]) stim_q.push_back(DIR_TAB[i]);
      end

      // sender holds off halfway until everything has come out
      queued = 0;
      while (queued < PHASE_ITEMS / 2) gen_value();
      drain();
      while (queued < PHASE_ITEMS) gen_value();
      drain();
    end

    if (errors == 0 && decoded_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ede_pkg.sv
rtl/ede_decode.sv
rtl/decimal_escape_decoder.sv
dv/decimal_escape_decoder_tb.sv
